// ===== src/ubx_pkg.sv =====
// Shared types and constants for the UBX frame decoder.
// Used by ubx_front, ubx_queue, ubx_back and ubx_frame_decoder; no dependencies.
`default_nettype none

package ubx_pkg;

    // Byte count saturates at this value
    localparam logic [16:0] POS_MAX = 17'h1FFFF;

    // Header bytes in front of the payload, and header plus checksum
    localparam logic [16:0] HEADER_LEN   = 17'd6;
    localparam logic [16:0] OVERHEAD_LEN = 17'd8;

    // Queue between front and back; depth is a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Register indexes of the configuration port
    localparam logic [1:0] CFG_SYNC_FIRST      = 2'd0;
    localparam logic [1:0] CFG_SYNC_SECOND     = 2'd1;
    localparam logic [1:0] CFG_MAX_PAYLOAD_LEN = 2'd2;

    // Reset values of the configuration registers
    localparam logic [7:0]  SYNC_FIRST_RESET  = 8'd181;
    localparam logic [7:0]  SYNC_SECOND_RESET = 8'd98;
    localparam logic [15:0] MAX_LEN_RESET     = 16'd1024;

    // Role of a byte within the frame
    typedef enum logic [3:0] {
        KIND_SYNC_A,
        KIND_SYNC_B,
        KIND_CLASS,
        KIND_ID,
        KIND_LEN_LO,
        KIND_LEN_HI,
        KIND_PAYLOAD,
        KIND_CK_A,
        KIND_CK_B,
        KIND_IGNORE
    } byte_kind_t;

    // Final frame status
    typedef enum logic [2:0] {
        STATUS_OK           = 3'd0,
        STATUS_BAD_LENGTH   = 3'd1,
        STATUS_BAD_SYNC     = 3'd2,
        STATUS_TOO_LARGE    = 3'd3,
        STATUS_BAD_CHECKSUM = 3'd4
    } frame_status_t;

    // One classified byte, as handed from front to back
    typedef struct packed {
        logic [7:0]  data;
        byte_kind_t  kind;
        logic [15:0] index;      // payload position
        logic        last;       // last byte of the buffer
        logic        too_short;  // total count below the minimum frame
        logic        len_wrong;  // total count differs from 8 plus length
    } item_t;

endpackage

`default_nettype wire

// ===== src/ubx_front.sv =====
// Front end: accepts raw bytes, tracks frame position and declared length,
// and classifies each byte. Depends on ubx_pkg.
`default_nettype none

module ubx_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    data_byte,
    input  wire logic          frame_end,
    input  wire logic          push_ready,
    output logic               push_valid,
    output ubx_pkg::item_t     push_item
);
    import ubx_pkg::*;

    logic [16:0] pos_reg;
    logic [16:0] pos_next;
    logic [15:0] len_reg;
    logic [15:0] len_next;
    logic [16:0] pos_inc;
    logic [16:0] offset;
    logic        accept;
    byte_kind_t  kind;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign accept     = in_valid && push_ready;

    // Classify the byte by its position
    always_comb
    begin
        offset   = pos_reg - HEADER_LEN;
        len_next = len_reg;
        case (pos_reg)
            17'd0: kind = KIND_SYNC_A;
            17'd1: kind = KIND_SYNC_B;
            17'd2: kind = KIND_CLASS;
            17'd3: kind = KIND_ID;
            17'd4:
            begin
                kind     = KIND_LEN_LO;
                len_next = {8'h00, data_byte};
            end
            17'd5:
            begin
                kind     = KIND_LEN_HI;
                len_next = {data_byte, len_reg[7:0]};
            end
            default:
            begin
                if (pos_reg == POS_MAX)
                    kind = KIND_IGNORE;
                else if (offset < {1'b0, len_reg})
                    kind = KIND_PAYLOAD;
                else if (offset == {1'b0, len_reg})
                    kind = KIND_CK_A;
                else if (offset == {1'b0, len_reg} + 17'd1)
                    kind = KIND_CK_B;
                else
                    kind = KIND_IGNORE;
            end
        endcase
    end

    // Advance the saturating count and judge the total on the last byte
    assign pos_inc  = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 17'd1;
    assign pos_next = frame_end ? 17'd0 : pos_inc;

    always_comb
    begin
        push_item.data      = data_byte;
        push_item.kind      = kind;
        push_item.index     = offset[15:0];
        push_item.last      = frame_end;
        push_item.too_short = pos_inc < OVERHEAD_LEN;
        push_item.len_wrong = pos_inc != (OVERHEAD_LEN + {1'b0, len_next});
    end

    // Hold position state; clear it at the end of a frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            len_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
            len_reg <= frame_end ? 16'd0 : len_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/ubx_queue.sv =====
// Short FIFO of classified bytes between front and back.
// Depends on ubx_pkg.
`default_nettype none

module ubx_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  ubx_pkg::item_t     push_item,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output ubx_pkg::item_t     pop_item
);
    import ubx_pkg::*;

    item_t                    mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0]   count_reg;
    logic [QUEUE_CNT_W-1:0]   count_next;
    logic                     push;
    logic                     pop;

    assign push_ready = count_reg != QUEUE_CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QUEUE_CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QUEUE_CNT_W'(1);
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            count_reg <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

// ===== src/ubx_back.sv =====
// Back end: holds the configuration, runs sync check, field capture and
// Fletcher sums, and drives the registered result. Depends on ubx_pkg.
`default_nettype none

module ubx_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_write,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [15:0]   cfg_data,
    input  wire logic          pop_valid,
    output logic               pop_ready,
    input  ubx_pkg::item_t     pop_item,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [7:0]         payload_byte,
    output logic               payload_valid,
    output logic [15:0]        payload_index,
    output logic               frame_done,
    output logic [2:0]         status,
    output logic [7:0]         message_class,
    output logic [7:0]         msg_id,
    output logic [15:0]        payload_length
);
    import ubx_pkg::*;

    // Configuration
    logic [7:0]    sync_first_reg;
    logic [7:0]    sync_second_reg;
    logic [15:0]   max_len_reg;

    // Frame state
    logic          sync_match_reg;
    logic          sync_match_next;
    logic [7:0]    class_reg;
    logic [7:0]    class_next;
    logic [7:0]    id_reg;
    logic [7:0]    id_next;
    logic [15:0]   length_reg;
    logic [15:0]   length_next;
    logic [7:0]    sum_a_reg;
    logic [7:0]    sum_a_next;
    logic [7:0]    sum_b_reg;
    logic [7:0]    sum_b_next;
    logic [15:0]   rcv_sums_reg;
    logic [15:0]   rcv_sums_next;
    logic          sum_en;
    frame_status_t frame_status;

    // Result register
    logic          out_valid_reg;
    logic [7:0]    payload_byte_reg;
    logic          payload_valid_reg;
    logic [15:0]   payload_index_reg;
    logic          frame_done_reg;
    frame_status_t status_reg;
    logic [7:0]    message_class_reg;
    logic [7:0]    msg_id_reg;
    logic [15:0]   payload_length_reg;
    logic          load;
    logic          is_payload;

    // Take a beat whenever the result register is free or draining
    assign load      = pop_valid && (!out_valid_reg || out_ready);
    assign pop_ready = load;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= SYNC_FIRST_RESET;
            sync_second_reg <= SYNC_SECOND_RESET;
            max_len_reg     <= MAX_LEN_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SYNC_FIRST:      sync_first_reg  <= cfg_data[7:0];
                CFG_SYNC_SECOND:     sync_second_reg <= cfg_data[7:0];
                CFG_MAX_PAYLOAD_LEN: max_len_reg     <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Apply one classified byte to the frame state
    always_comb
    begin
        sync_match_next = sync_match_reg;
        class_next      = class_reg;
        id_next         = id_reg;
        length_next     = length_reg;
        rcv_sums_next   = rcv_sums_reg;
        sum_en          = 1'b0;
        case (pop_item.kind)
            KIND_SYNC_A: sync_match_next = pop_item.data == sync_first_reg;
            KIND_SYNC_B:
                sync_match_next = sync_match_reg && (pop_item.data == sync_second_reg);
            KIND_CLASS:
            begin
                class_next = pop_item.data;
                sum_en     = 1'b1;
            end
            KIND_ID:
            begin
                id_next = pop_item.data;
                sum_en  = 1'b1;
            end
            KIND_LEN_LO:
            begin
                length_next = {8'h00, pop_item.data};
                sum_en      = 1'b1;
            end
            KIND_LEN_HI:
            begin
                length_next = {pop_item.data, length_reg[7:0]};
                sum_en      = 1'b1;
            end
            KIND_PAYLOAD: sum_en = 1'b1;
            KIND_CK_A:    rcv_sums_next = {rcv_sums_reg[15:8], pop_item.data};
            KIND_CK_B:    rcv_sums_next = {pop_item.data, rcv_sums_reg[7:0]};
            default:      ;
        endcase
        sum_a_next = sum_en ? sum_a_reg + pop_item.data : sum_a_reg;
        sum_b_next = sum_en ? sum_b_reg + sum_a_next : sum_b_reg;
    end

    assign is_payload = pop_item.kind == KIND_PAYLOAD;

    // Rank the frame errors
    always_comb
    begin
        if (pop_item.too_short)
            frame_status = STATUS_BAD_LENGTH;
        else if (!sync_match_next)
            frame_status = STATUS_BAD_SYNC;
        else if (length_next > max_len_reg)
            frame_status = STATUS_TOO_LARGE;
        else if (pop_item.len_wrong)
            frame_status = STATUS_BAD_LENGTH;
        else if (rcv_sums_next != {sum_b_next, sum_a_next})
            frame_status = STATUS_BAD_CHECKSUM;
        else
            frame_status = STATUS_OK;
    end

    // Hold frame state; return it to reset after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_match_reg <= 1'b1;
            class_reg      <= '0;
            id_reg         <= '0;
            length_reg     <= '0;
            sum_a_reg      <= '0;
            sum_b_reg      <= '0;
            rcv_sums_reg   <= '0;
        end
        else if (load)
        begin
            if (pop_item.last)
            begin
                sync_match_reg <= 1'b1;
                class_reg      <= '0;
                id_reg         <= '0;
                length_reg     <= '0;
                sum_a_reg      <= '0;
                sum_b_reg      <= '0;
                rcv_sums_reg   <= '0;
            end
            else
            begin
                sync_match_reg <= sync_match_next;
                class_reg      <= class_next;
                id_reg         <= id_next;
                length_reg     <= length_next;
                sum_a_reg      <= sum_a_next;
                sum_b_reg      <= sum_b_next;
                rcv_sums_reg   <= rcv_sums_next;
            end
        end
    end

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            payload_byte_reg   <= is_payload ? pop_item.data : 8'h00;
            payload_valid_reg  <= is_payload;
            payload_index_reg  <= is_payload ? pop_item.index : 16'h0000;
            frame_done_reg     <= pop_item.last;
            status_reg         <= pop_item.last ? frame_status : STATUS_OK;
            message_class_reg  <= pop_item.last ? class_next : 8'h00;
            msg_id_reg         <= pop_item.last ? id_next : 8'h00;
            payload_length_reg <= pop_item.last ? length_next : 16'h0000;
        end
    end

    assign out_valid      = out_valid_reg;
    assign payload_byte   = payload_byte_reg;
    assign payload_valid  = payload_valid_reg;
    assign payload_index  = payload_index_reg;
    assign frame_done     = frame_done_reg;
    assign status         = status_reg;
    assign message_class  = message_class_reg;
    assign msg_id         = msg_id_reg;
    assign payload_length = payload_length_reg;

endmodule

`default_nettype wire

// ===== src/ubx_frame_decoder.sv =====
// Top level of the UBX frame decoder: front classifier, queue, back end.
// Depends on ubx_pkg, ubx_front, ubx_queue and ubx_back.
//
//   channel  | handshake           | beat contents
//   ---------+---------------------+---------------------------------------------
//   input    | in_valid/in_ready   | data_byte, frame_end
//   output   | out_valid/out_ready | payload_byte, payload_valid, payload_index,
//            |                     | frame_done, status, message_class, msg_id,
//            |                     | payload_length
//   config   | cfg_write           | cfg_index, cfg_data
//
// One byte per cycle sustained while out_ready stays high; each accepted byte yields
// one result, registered first in a queue entry and then in the result register.
// The two-entry queue lets the front keep accepting while a result waits.
// Reset is asynchronous and active low; configuration returns to its defaults.
// When out_ready is low the decoder holds up to three beats (two queued, one
// in the result register), then in_ready drops.
`default_nettype none

module ubx_frame_decoder (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_write,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [15:0]   cfg_data,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    data_byte,
    input  wire logic          frame_end,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [7:0]         payload_byte,
    output logic               payload_valid,
    output logic [15:0]        payload_index,
    output logic               frame_done,
    output logic [2:0]         status,
    output logic [7:0]         message_class,
    output logic [7:0]         msg_id,
    output logic [15:0]        payload_length
);
    import ubx_pkg::*;

    logic  push_valid;
    logic  push_ready;
    item_t push_item;
    logic  pop_valid;
    logic  pop_ready;
    item_t pop_item;

    // Classify incoming bytes
    ubx_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .frame_end  (frame_end),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_item  (push_item)
    );

    // Decouple front and back
    ubx_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // Check, sum and report
    ubx_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_item       (pop_item),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .payload_byte   (payload_byte),
        .payload_valid  (payload_valid),
        .payload_index  (payload_index),
        .frame_done     (frame_done),
        .status         (status),
        .message_class  (message_class),
        .msg_id         (msg_id),
        .payload_length (payload_length)
    );

endmodule

`default_nettype wire

// ===== sim/ubx_check_pkg.sv =====
// Result tracker for the UBX frame decoder testbench: predicts one result per byte
// and checks the decoder's results against them in order.
// Depends on ubx_pkg for the status codes, register indexes and frame constants.
package ubx_check_pkg;

    import ubx_pkg::*;

    // One decoder result, field by field
    typedef struct packed {
        logic [7:0]    payload_byte;
        logic          payload_valid;
        logic [15:0]   payload_index;
        logic          frame_done;
        frame_status_t status;
        logic [7:0]    message_class;
        logic [7:0]    msg_id;
        logic [15:0]   payload_length;
    } frame_result_t;

    class ubx_frame_tracker;

        // Configuration as last written
        logic [7:0]  exp_sync0;
        logic [7:0]  exp_sync1;
        logic [15:0] len_limit;

        // Per-frame state
        logic [16:0] byte_count;
        bit          sync_good;
        logic [7:0]  cls_seen;
        logic [7:0]  id_seen;
        logic [15:0] len_seen;
        logic [7:0]  fl_a;
        logic [7:0]  fl_b;
        logic [15:0] ck_rx;

        frame_result_t pending_results[$];
        int            mismatches;

        function new();
            exp_sync0   = SYNC_FIRST_RESET;
            exp_sync1   = SYNC_SECOND_RESET;
            len_limit   = MAX_LEN_RESET;
            mismatches  = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            byte_count = '0;
            sync_good  = 1'b1;
            cls_seen   = '0;
            id_seen    = '0;
            len_seen   = '0;
            fl_a       = '0;
            fl_b       = '0;
            ck_rx      = '0;
        endfunction

        // Mirror a register write; unknown indexes are dropped
        function void set_reg(logic [1:0] idx, logic [15:0] value);
            case (idx)
                CFG_SYNC_FIRST:      exp_sync0 = value[7:0];
                CFG_SYNC_SECOND:     exp_sync1 = value[7:0];
                CFG_MAX_PAYLOAD_LEN: len_limit = value;
                default: ;
            endcase
        endfunction

        function void add_sum(logic [7:0] b);
            fl_a = fl_a + b;
            fl_b = fl_b + fl_a;
        endfunction

        // Work out the result of one accepted input beat
        function void note_byte(logic [7:0] b, logic last);
            frame_result_t r;
            logic [16:0]   pos;
            logic [16:0]   off;
            r   = '0;
            pos = byte_count;
            off = pos - HEADER_LEN;

            if (pos == 17'd0) begin
                sync_good = (b == exp_sync0);
            end else if (pos == 17'd1) begin
                sync_good = sync_good && (b == exp_sync1);
            end else if (pos == 17'd2) begin
                cls_seen = b;
                add_sum(b);
            end else if (pos == 17'd3) begin
                id_seen = b;
                add_sum(b);
            end else if (pos == 17'd4) begin
                len_seen = {8'h00, b};
                add_sum(b);
            end else if (pos == 17'd5) begin
                len_seen[15:8] = b;
                add_sum(b);
            end else if (pos < POS_MAX) begin
                // Payload up to the declared length, then the two checksum bytes
                if (off < {1'b0, len_seen}) begin
                    add_sum(b);
                    r.payload_byte  = b;
                    r.payload_valid = 1'b1;
                    r.payload_index = off[15:0];
                end else if (off == {1'b0, len_seen}) begin
                    ck_rx[7:0] = b;
                end else if (off == {1'b0, len_seen} + 17'd1) begin
                    ck_rx[15:8] = b;
                end
            end

            // Saturate the count
            if (byte_count < POS_MAX) begin
                byte_count = byte_count + 17'd1;
            end

            if (last) begin
                r.frame_done = 1'b1;
                if (byte_count < OVERHEAD_LEN) begin
                    r.status = STATUS_BAD_LENGTH;
                end else if (!sync_good) begin
                    r.status = STATUS_BAD_SYNC;
                end else if (len_seen > len_limit) begin
                    r.status = STATUS_TOO_LARGE;
                end else if (byte_count != OVERHEAD_LEN + {1'b0, len_seen}) begin
                    r.status = STATUS_BAD_LENGTH;
                end else if (ck_rx != {fl_b, fl_a}) begin
                    r.status = STATUS_BAD_CHECKSUM;
                end else begin
                    r.status = STATUS_OK;
                end
                r.message_class  = cls_seen;
                r.msg_id         = id_seen;
                r.payload_length = len_seen;
                clear_frame();
            end
            pending_results.push_back(r);
        endfunction

        function void flag_field(string field, int unsigned want, int unsigned got);
            $error("%s: expected %0d, actual %0d", field, want, got);
            mismatches++;
        endfunction

        // Compare one output beat with the oldest prediction
        function void check_result(frame_result_t got);
            frame_result_t want;
            if (pending_results.size() == 0) begin
                $error("result with no byte waiting: payload_byte %0d, frame_done %0d",
                       got.payload_byte, got.frame_done);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (got.payload_byte !== want.payload_byte)
                flag_field("payload_byte", want.payload_byte, got.payload_byte);
            if (got.payload_valid !== want.payload_valid)
                flag_field("payload_valid", want.payload_valid, got.payload_valid);
            if (got.payload_index !== want.payload_index)
                flag_field("payload_index", want.payload_index, got.payload_index);
            if (got.frame_done !== want.frame_done)
                flag_field("frame_done", want.frame_done, got.frame_done);
            if (got.status !== want.status)
                flag_field("status", int'(want.status), int'(got.status));
            if (got.message_class !== want.message_class)
                flag_field("message_class", want.message_class, got.message_class);
            if (got.msg_id !== want.msg_id)
                flag_field("msg_id", want.msg_id, got.msg_id);
            if (got.payload_length !== want.payload_length)
                flag_field("payload_length", want.payload_length, got.payload_length);
        endfunction

        // Report predictions that never got a result
        function void check_drained();
            if (pending_results.size() != 0) begin
                $error("%0d results never arrived", pending_results.size());
                mismatches++;
            end
        endfunction

    endclass

endpackage

// ===== sim/tb.sv =====
// Testbench for ubx_frame_decoder: random well-formed and broken UBX frames under
// random idling on both handshakes, checked beat by beat against ubx_check_pkg.
// Depends on ubx_pkg, ubx_check_pkg and the decoder RTL.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ubx_pkg::*;
    import ubx_check_pkg::*;

    // Register index past the list; writes to it must be dropped
    localparam logic [1:0] CFG_NONE = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        frame_end;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic [15:0] payload_index;
    logic        frame_done;
    logic [2:0]  status;
    logic [7:0]  message_class;
    logic [7:0]  msg_id;
    logic [15:0] payload_length;

    ubx_frame_tracker tracker;
    frame_result_t    observed;
    logic [7:0]       frame_bytes[$];
    bit               quiet;
    bit               stall_done;
    int               bytes_sent;
    int               results_seen;

    ubx_frame_decoder u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .frame_end      (frame_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .payload_byte   (payload_byte),
        .payload_valid  (payload_valid),
        .payload_index  (payload_index),
        .frame_done     (frame_done),
        .status         (status),
        .message_class  (message_class),
        .msg_id         (msg_id),
        .payload_length (payload_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Offer one beat, hold it until accepted, then note it
    task automatic send_byte(input logic [7:0] value, input logic last);
        while (!quiet && $urandom_range(99) < 21)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= value;
        frame_end <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        tracker.note_byte(value, last);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i])
        begin
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        end
    endtask

    // Header with the current sync bytes, pay_n payload bytes, then the two sums
    task automatic build_frame(input logic [15:0] len, input int pay_n, input bit bad_ck);
        logic [7:0] ca;
        logic [7:0] cb;
        logic [7:0] v;
        frame_bytes.delete();
        frame_bytes.push_back(tracker.exp_sync0);
        frame_bytes.push_back(tracker.exp_sync1);
        frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(len[7:0]);
        frame_bytes.push_back(len[15:8]);
        ca = '0;
        cb = '0;
        for (int i = 2; i < 6; i++)
        begin
            ca = ca + frame_bytes[i];
            cb = cb + ca;
        end
        repeat (pay_n)
        begin
            v  = 8'($urandom);
            ca = ca + v;
            cb = cb + ca;
            frame_bytes.push_back(v);
        end
        if (bad_ck)
        begin
            if ($urandom_range(1) == 1)
                ca = ca ^ (8'd1 << $urandom_range(7));
            else
                cb = cb ^ (8'd1 << $urandom_range(7));
        end
        frame_bytes.push_back(ca);
        frame_bytes.push_back(cb);
    endtask

    // Pick one buffer: mostly good frames, the rest broken frames and noise
    task automatic gen_frame();
        int          pick;
        int          lim;
        int          n;
        int          k;
        logic [15:0] len;
        pick = $urandom_range(99);
        lim  = (tracker.len_limit < 16) ? tracker.len_limit : 16;
        if ($urandom_range(19) == 0)
            lim = (tracker.len_limit < 300) ? tracker.len_limit : 300;
        len = 16'($urandom_range(lim, 0));

        if (pick >= 95)
        begin
            // noise, sometimes behind a valid sync pair
            frame_bytes.delete();
            if ($urandom_range(2) == 0)
            begin
                frame_bytes.push_back(tracker.exp_sync0);
                frame_bytes.push_back(tracker.exp_sync1);
            end
            n = $urandom_range(12, 1);
            repeat (n) frame_bytes.push_back(8'($urandom));
        end
        else if (pick >= 88 && tracker.len_limit != 16'hFFFF)
        begin
            // declared length past the limit, with at most four payload bytes
            if ($urandom_range(1) == 1)
                len = tracker.len_limit + 16'd1;
            else
                len = 16'($urandom_range(65535, tracker.len_limit + 1));
            build_frame(len, $urandom_range(4), 1'b0);
        end
        else
        begin
            build_frame(len, len, pick >= 65 && pick < 72);
            if (pick >= 72 && pick < 78)
            begin
                k = $urandom_range(1);
                frame_bytes[k] = frame_bytes[k] ^ (8'd1 << $urandom_range(7));
            end
            else if (pick >= 78 && pick < 84)
            begin
                n = $urandom_range(frame_bytes.size() - 1, 1);
                while (frame_bytes.size() > n) void'(frame_bytes.pop_back());
            end
            else if (pick >= 84 && pick < 88)
            begin
                n = $urandom_range(3, 1);
                repeat (n) frame_bytes.push_back(8'($urandom));
            end
        end
    endtask

    task automatic run_random(input int budget);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < budget)
        begin
            gen_frame();
            send_frame();
        end
    endtask

    // Drop valid and wait until every predicted result is out
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        tracker.set_reg(idx, value);
        @(negedge clk);
    endtask

    // Receiver: random stalls, plus one long hold-off to fill the decoder
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!stall_done && results_seen >= 300)
            begin
                stall_done = 1'b1;
                out_ready <= 1'b0;
                repeat (300) @(negedge clk);
            end
            out_ready <= quiet || ($urandom_range(99) >= 21);
        end
    end

    // Check every output beat at the clock edge that accepts it
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            observed.payload_byte   = payload_byte;
            observed.payload_valid  = payload_valid;
            observed.payload_index  = payload_index;
            observed.frame_done     = frame_done;
            observed.status         = frame_status_t'(status);
            observed.message_class  = message_class;
            observed.msg_id         = msg_id;
            observed.payload_length = payload_length;
            tracker.check_result(observed);
            results_seen++;
        end
    end

    initial
    begin
        int drain_cycles;
        tracker    = new();
        quiet      = 1'b0;
        stall_done = 1'b0;
        bytes_sent   = 0;
        results_seen = 0;
        rst_n      = 1'b0;
        cfg_write  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        data_byte  = '0;
        frame_end  = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Directed: lone byte, empty good frame, one-byte payload, bad checksum
        frame_bytes = '{8'hFF};
        send_frame();
        build_frame(16'd0, 0, 1'b0);
        send_frame();
        build_frame(16'd1, 1, 1'b0);
        send_frame();
        build_frame(16'd0, 0, 1'b1);
        send_frame();

        // Reset settings; the long receiver hold-off lands here
        run_random(400);

        // Extremes: sync 00/FF with junk in the upper data bits, no payload allowed
        wait_idle();
        write_reg(CFG_SYNC_FIRST, {8'($urandom), 8'h00});
        write_reg(CFG_SYNC_SECOND, {8'($urandom), 8'hFF});
        write_reg(CFG_MAX_PAYLOAD_LEN, 16'h0000);
        run_random(350);

        // Largest limit, sync FF/00 with junk in the upper data bits
        wait_idle();
        write_reg(CFG_SYNC_FIRST, 16'h00FF);
        write_reg(CFG_SYNC_SECOND, 16'hFF00);
        write_reg(CFG_MAX_PAYLOAD_LEN, 16'hFFFF);
        run_random(350);

        // Random settings, an ignored index, and a stretch without idling
        wait_idle();
        write_reg(CFG_NONE, 16'($urandom));
        write_reg(CFG_SYNC_FIRST, 16'($urandom));
        write_reg(CFG_SYNC_SECOND, 16'($urandom));
        write_reg(CFG_MAX_PAYLOAD_LEN, 16'($urandom_range(200, 1)));
        quiet = 1'b1;
        run_random(175);
        quiet = 1'b0;
        run_random(175);

        // Back to the usual sync pair with a tight limit
        wait_idle();
        write_reg(CFG_SYNC_FIRST, {8'h00, SYNC_FIRST_RESET});
        write_reg(CFG_SYNC_SECOND, {8'h00, SYNC_SECOND_RESET});
        write_reg(CFG_MAX_PAYLOAD_LEN, 16'd40);
        run_random(350);

        // Drain, then leave time for stray beats
        in_valid <= 1'b0;
        drain_cycles = 0;
        while (tracker.pending_results.size() != 0 && drain_cycles < 20000)
        begin
            @(negedge clk);
            drain_cycles++;
        end
        repeat (10) @(negedge clk);
        tracker.check_drained();
        if (tracker.mismatches == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    // Hang guard
    initial
    begin
        #40_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
